// ----- rtl/cfec_pkg.sv -----
// Package with widths, constants and the arctangent table for the cubemap coordinate block.
package cfec_pkg;

  localparam int FRAC_BITS_DEF     = 8;
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int ATAN_ENTRIES      = 24;
  localparam int PRESCALE_BITS     = 16;
  // Ray datapath width: |component| < 2^13, scaled 2^16, grown by CORDIC gain.
  localparam int RAY_W             = 34;
  localparam int WIDTH_W           = 14;
  localparam int HEIGHT_W          = 13;
  localparam int EDGE_W            = 12;
  localparam int OUT_W             = 21;
  localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_EDGE   = 2'd2;

  localparam logic [2:0] FACE_NX   = 3'd1;
  localparam logic [2:0] FACE_PY   = 3'd2;
  localparam logic [2:0] FACE_NY   = 3'd3;
  localparam logic [2:0] FACE_UP   = 3'd4;
  localparam logic [2:0] FACE_DOWN = 3'd5;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335086;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41721;
      5'd15: t = 32'd20860;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2607;
      5'd19: t = 32'd1303;
      5'd20: t = 32'd651;
      5'd21: t = 32'd325;
      5'd22: t = 32'd162;
      5'd23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/cfec_cordic.sv -----
// Pipelined CORDIC vectoring unit: a folding stage, then one micro-rotation per register stage.
module cfec_cordic #(
  parameter int STAGES = cfec_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [cfec_pkg::RAY_W-1:0] in_x,
  input  logic signed [cfec_pkg::RAY_W-1:0] in_y,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [31:0]                       out_ang,
  output logic signed [cfec_pkg::RAY_W-1:0] out_mag,
  output logic [SIDE_W-1:0]                 out_side
);

  localparam int N = (STAGES < cfec_pkg::ATAN_ENTRIES) ? STAGES : cfec_pkg::ATAN_ENTRIES;
  localparam int RW = cfec_pkg::RAY_W;

  logic signed [RW-1:0] x_r [0:N];
  logic signed [RW-1:0] y_r [0:N];
  logic [31:0]          z_r [0:N];
  logic                 zero_r [0:N];
  logic [SIDE_W-1:0]    side_r [0:N];
  logic                 v_r [0:N];

  // Stage 0 folds the left half-plane and flags the zero vector.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      side_r[0] <= in_side;
      if (in_x < 0) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= 32'h8000_0000;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= 32'd0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [RW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + cfec_pkg::atan_turn(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - cfec_pkg::atan_turn(5'(i));
        end
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_ang   = zero_r[N] ? 32'd0 : z_r[N];
  assign out_mag   = zero_r[N] ? '0 : x_r[N];
  assign out_side  = side_r[N];

endmodule

// ----- rtl/cubemap_face_to_equirect_coord_top.sv -----
// Top level: cube-face pixel to equirectangular source coordinate, fully pipelined.
// Throughput: one item per clock unless out_tvalid is high and out_tready low.
// Pipeline order: stage A, longitude CORDIC, stage B, latitude CORDIC, stages C, D
// and the output register. Stalls freeze the whole pipeline; out_tready low
// holds the output register. rst_n (synchronous, active low) clears all valid
// bits and loads the registers with width 4096, height 2048, face edge 1024.
module cubemap_face_to_equirect_coord_top #(
  parameter int FRAC_BITS     = cfec_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = cfec_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // face [2:0], col [13:3], row [24:14], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // src_x_q8 [20:0], src_y_q8 [41:21], zeros above
);

  localparam int RW  = cfec_pkg::RAY_W;
  localparam int OW  = cfec_pkg::OUT_W;
  localparam int PS  = cfec_pkg::PRESCALE_BITS;

  logic [13:0] width_r;
  logic [12:0] height_r;
  logic [11:0] edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 14'd4096;
      height_r <= 13'd2048;
      edge_r   <= 12'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        cfec_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        cfec_pkg::CFG_HEIGHT: height_r <= cfg_wdata[12:0];
        cfec_pkg::CFG_EDGE:   edge_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output register is free or being taken.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage A: face-local ray and axis permutation.
  logic [2:0]  face;
  logic [10:0] col, row;
  assign face = in_tdata[2:0];
  assign col  = in_tdata[13:3];
  assign row  = in_tdata[24:14];

  logic signed [14:0] lx, ly, lz, px, py, pz;
  always_comb begin
    lx = 15'(edge_r);
    ly = 15'(edge_r) - 15'({col, 1'b0}) - 15'sd1;
    lz = 15'(edge_r) - 15'({row, 1'b0}) - 15'sd1;
    case (face)
      cfec_pkg::FACE_NX:   begin px = -lx; py = -ly; pz = lz;  end
      cfec_pkg::FACE_PY:   begin px = -ly; py = lx;  pz = lz;  end
      cfec_pkg::FACE_NY:   begin px = ly;  py = -lx; pz = lz;  end
      cfec_pkg::FACE_UP:   begin px = -lz; py = ly;  pz = lx;  end
      cfec_pkg::FACE_DOWN: begin px = lz;  py = ly;  pz = -lx; end
      default:             begin px = lx;  py = ly;  pz = lz;  end
    endcase
  end

  logic               a_v_r;
  logic signed [14:0] a_px_r, a_ny_r, a_pz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_tvalid;
    if (en) begin
      a_px_r <= px;
      a_ny_r <= -py;
      a_pz_r <= pz;
    end
  end

  // Longitude pass; the latitude Z rides along as side data and is gain-corrected in stage B.
  logic               lon_v;
  logic [31:0]        lon_ang;
  logic signed [RW-1:0] lon_mag;
  logic [14:0]        lon_side;
  cfec_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(15)) u_lon (
    .clk, .rst_n, .en,
    .in_valid (a_v_r),
    .in_x     (RW'(a_px_r) <<< PS),
    .in_y     (RW'(a_ny_r) <<< PS),
    .in_side  (a_pz_r),
    .out_valid(lon_v),
    .out_ang  (lon_ang),
    .out_mag  (lon_mag),
    .out_side (lon_side)
  );

  // Stage B: Z*2^16*gain/2^30 with half-away rounding: |pz| * gain, 15x31 bits.
  logic        b_v_r, b_neg_r;
  logic [45:0] b_prod_r;
  logic [31:0] b_ang_r;
  logic signed [RW-1:0] b_mag_r;
  logic signed [14:0] pz_s;
  logic [14:0] pz_abs;
  assign pz_s   = lon_side;
  assign pz_abs = pz_s[14] ? 15'(-pz_s) : 15'(pz_s);
  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= lon_v;
    if (en) begin
      b_neg_r  <= pz_s[14];
      b_prod_r <= 46'(pz_abs) * 46'(cfec_pkg::GAIN_Q30);
      b_ang_r  <= lon_ang;
      b_mag_r  <= lon_mag;
    end
  end

  // Rounded magnitude: (p*2^16 + 2^29) >> 30 = (p + 2^13) >> 14.
  logic [45:0] zk_abs;
  logic signed [RW-1:0] zk;
  assign zk_abs = (b_prod_r + 46'd8192) >> 14;
  assign zk     = b_neg_r ? -RW'(zk_abs) : RW'(zk_abs);

  logic        lat_v;
  logic [31:0] lat_ang;
  logic signed [RW-1:0] lat_mag;
  logic [31:0] lat_side;
  cfec_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(32)) u_lat (
    .clk, .rst_n, .en,
    .in_valid (b_v_r),
    .in_x     (b_mag_r),
    .in_y     (zk),
    .in_side  (b_ang_r),
    .out_valid(lat_v),
    .out_ang  (lat_ang),
    .out_mag  (lat_mag),
    .out_side (lat_side)
  );

  // Stage C: the two scaling products, 32x14 and 32x13 bits.
  logic        c_v_r;
  logic [45:0] c_xp_r;
  logic signed [45:0] c_yp_r;
  logic [31:0] u;
  assign u = lat_side + 32'h8000_0000;
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= lat_v;
    if (en) begin
      c_xp_r <= 46'(u) * 46'(width_r);
      c_yp_r <= 46'(signed'(lat_ang)) * signed'(46'(height_r));
    end
  end

  // Stage D: rounding shifts and offsets.
  localparam int XS = 32 - FRAC_BITS;
  localparam int YS = 31 - FRAC_BITS;
  localparam int XW = 48;
  logic signed [XW-1:0] xq0, span, yq0, yr;
  logic [45:0] y_abs, y_absr;
  always_comb begin
    xq0 = XW'((c_xp_r + (46'd1 << (XS - 1))) >> XS)
          - (XW'(1) <<< (FRAC_BITS - 1));
    y_abs  = c_yp_r[45] ? 46'(-c_yp_r) : 46'(c_yp_r);
    y_absr = (y_abs + (46'd1 << (YS - 1))) >> YS;
    yr     = c_yp_r[45] ? -XW'(y_absr) : XW'(y_absr);
    yq0    = (XW'(height_r) <<< (FRAC_BITS - 1)) - yr - (XW'(1) <<< (FRAC_BITS - 1));
    span   = XW'(width_r) <<< FRAC_BITS;
  end

  logic        d_v_r;
  logic signed [XW-1:0] d_x_r, d_span_r;
  logic [OW-1:0] d_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (en) d_v_r <= c_v_r;
    if (en) begin
      d_x_r    <= xq0;
      d_span_r <= span;
      d_y_r    <= yq0[OW-1:0];
    end
  end

  // Stage E: single wrap of x and a clamp at zero, then the output register.
  logic signed [XW-1:0] x1, x2, x3;
  always_comb begin
    x1 = (d_x_r < 0) ? d_x_r + d_span_r : d_x_r;
    x2 = (x1 >= d_span_r) ? x1 - d_span_r : x1;
    x3 = (x2 < 0) ? '0 : x2;
  end

  logic          o_v_r;
  logic [OW-1:0] o_x_r, o_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= d_v_r;
    if (en) begin
      o_x_r <= x3[OW-1:0];
      o_y_r <= d_y_r;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {6'd0, o_y_r, o_x_r};

endmodule

// ----- bench/cubemap_face_to_equirect_coord_top_tb.sv -----
// Self-checking testbench for the cube-face to equirectangular coordinate block.
`timescale 1ns / 1ps

module cubemap_face_to_equirect_coord_top_tb;

  // This class predicts source coordinates and holds the coordinates still awaited.
  class coord_scoreboard;
    localparam int FRAC = 8;
    localparam int STAGES = 18;
    bit [31:0] turn_tab [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81};
    longint img_w = 4096;
    longint img_h = 2048;
    longint edge_len = 1024;
    bit [41:0] pending_coords [$];
    int mismatches = 0;
    int matched = 0;

    function void set_reg(logic [1:0] idx, logic [13:0] val);
      case (idx)
        cfec_pkg::CFG_WIDTH:  img_w = val;
        cfec_pkg::CFG_HEIGHT: img_h = val[12:0];
        cfec_pkg::CFG_EDGE:   edge_len = val[11:0];
        default: ;
      endcase
    endfunction

    // Vectoring rotation: angle in binary turns, magnitude with gain.
    function void vector_rotate(longint x0, longint y0, output bit [31:0] ang,
                                output longint mag);
      longint x, y, dx, dy;
      bit [31:0] z;
      x = x0;
      y = y0;
      z = 0;
      if (x == 0 && y == 0) begin
        ang = 0;
        mag = 0;
        return;
      end
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += turn_tab[i];
        end else begin
          x -= dx;
          y += dy;
          z -= turn_tab[i];
        end
      end
      ang = z;
      mag = x;
    endfunction

    function bit [41:0] predict_coord(logic [2:0] face, logic [10:0] col, logic [10:0] row);
      longint lx, ly, lz, px, py, pz, zs, zk, latz, xq, yq, span, prod, half;
      bit [31:0] lon_ang, lat_ang, u;
      longint lon_mag, lat_mag;
      lx = edge_len;
      ly = edge_len - 2 * longint'(col) - 1;
      lz = edge_len - 2 * longint'(row) - 1;
      case (face)
        cfec_pkg::FACE_NX:   begin px = -lx; py = -ly; pz = lz;  end
        cfec_pkg::FACE_PY:   begin px = -ly; py = lx;  pz = lz;  end
        cfec_pkg::FACE_NY:   begin px = ly;  py = -lx; pz = lz;  end
        cfec_pkg::FACE_UP:   begin px = -lz; py = ly;  pz = lx;  end
        cfec_pkg::FACE_DOWN: begin px = lz;  py = ly;  pz = -lx; end
        default:             begin px = lx;  py = ly;  pz = lz;  end
      endcase
      vector_rotate(px <<< 16, -(py <<< 16), lon_ang, lon_mag);
      zs = pz <<< 16;
      // The latitude pass sees a magnitude with CORDIC gain, so Z gets it too.
      if (zs < 0) zk = -((-zs * 64'sd1768195363 + (64'sd1 << 29)) >>> 30);
      else zk = (zs * 64'sd1768195363 + (64'sd1 << 29)) >>> 30;
      vector_rotate(lon_mag, zk, lat_ang, lat_mag);
      latz = longint'($signed(lat_ang));
      u = lon_ang + 32'h8000_0000;
      xq = ((longint'(u) * img_w + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC))
           - (64'sd1 << (FRAC - 1));
      span = img_w <<< FRAC;
      if (xq < 0) xq += span;
      if (xq >= span) xq -= span;
      if (xq < 0) xq = 0;
      prod = latz * img_h;
      half = 64'sd1 << (30 - FRAC);
      if (prod < 0) prod = -((-prod + half) >>> (31 - FRAC));
      else prod = (prod + half) >>> (31 - FRAC);
      yq = (img_h <<< (FRAC - 1)) - prod - (64'sd1 << (FRAC - 1));
      return {yq[20:0], xq[20:0]};
    endfunction

    function void note_input(logic [31:0] data);
      pending_coords = {pending_coords,
                        predict_coord(data[2:0], data[13:3], data[24:14])};
    endfunction

    function void check_result(logic [47:0] data);
      bit [41:0] want;
      if (pending_coords.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", data);
        return;
      end
      want = pending_coords.pop_front();
      if (data[20:0] !== want[20:0] || data[41:21] !== want[41:21]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: x exp %0d got %0d, y exp %0d got %0d",
                   want[20:0], data[20:0], $signed(want[41:21]), $signed(data[41:21]));
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = cfec_pkg::CFG_WIDTH;
  logic [13:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // face [2:0], col [13:3], row [24:14], zeros above
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // src_x_q8 [20:0], src_y_q8 [41:21], zeros above

  coord_scoreboard coord_sb = new();

  // Idling on both sides is switched off for the final stretch of the run.
  bit idle_on = 1'b1;
  // A request from the stimulus for one long receiver hold-off.
  bit long_hold = 1'b0;
  int pixels_sent = 0;

  always #2 clk = ~clk;

  cubemap_face_to_equirect_coord_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Results are sampled at the rising edge where the handshake completes.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) coord_sb.check_result(out_tdata);
  end

  // Receiver: random stall bursts, one long hold-off on request, then steady.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready = 1'b0;
        for (n = 0; n < 300; n++) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Offers one pixel at the falling edge and holds it until it is taken.
  // The caller returns at a falling edge, so the next pixel can follow at once.
  task automatic send_pixel(logic [2:0] face, logic [10:0] col, logic [10:0] row);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tdata = {7'b0, row, col, face};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    coord_sb.note_input(in_tdata);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted coordinate is back, then for a margin longer than the pipeline depth.
  task automatic drain();
    in_tvalid = 1'b0;
    while (coord_sb.pending_coords.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    coord_sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly pixels inside the face; a few use any 11-bit column or row.
  task automatic random_pixels(int count);
    logic [10:0] c, r;
    int lim;
    lim = (coord_sb.edge_len > 2048) ? 2047 : int'(coord_sb.edge_len) - 1;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = 11'($urandom);
        r = 11'($urandom);
      end else begin
        c = 11'($urandom_range(0, lim));
        r = 11'($urandom_range(0, lim));
      end
      send_pixel(($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5)), c, r);
    end
  endtask

  initial begin
    int e;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: every face code (including the unused six and seven), corners,
    // the center pixel, and columns and rows beyond the face edge.
    for (int f = 0; f < 8; f++) begin
      send_pixel(3'(f), 11'd0, 11'd0);
      send_pixel(3'(f), 11'd1023, 11'd1023);
    end
    send_pixel(cfec_pkg::FACE_UP, 11'd512, 11'd512);
    send_pixel(cfec_pkg::FACE_DOWN, 11'd2047, 11'd2047);
    send_pixel(3'd0, 11'd2047, 11'd0);
    send_pixel(cfec_pkg::FACE_NX, 11'd0, 11'd2047);
    drain();

    // Edge of one pixel: the face center gives a zero longitude vector on the up and down faces.
    write_reg(cfec_pkg::CFG_WIDTH, 14'd1);
    write_reg(cfec_pkg::CFG_HEIGHT, 14'd1);
    write_reg(cfec_pkg::CFG_EDGE, 14'd1);
    for (int f = 0; f < 6; f++) send_pixel(3'(f), 11'd0, 11'd0);
    random_pixels(150);
    drain();

    // Large settings, with a long receiver hold-off so the pipeline backs up.
    write_reg(cfec_pkg::CFG_WIDTH, 14'd8192);
    write_reg(cfec_pkg::CFG_HEIGHT, 14'd4096);
    write_reg(cfec_pkg::CFG_EDGE, 14'd2048);
    long_hold = 1'b1;
    random_pixels(450);
    drain();

    // Odd edge, so the center column and row give zero components.
    write_reg(cfec_pkg::CFG_WIDTH, 14'd3000);
    write_reg(cfec_pkg::CFG_HEIGHT, 14'd1499);
    write_reg(cfec_pkg::CFG_EDGE, 14'd513);
    send_pixel(cfec_pkg::FACE_UP, 11'd256, 11'd256);
    send_pixel(cfec_pkg::FACE_DOWN, 11'd256, 11'd256);
    random_pixels(450);
    drain();

    // Random settings; the final part runs with no idling on either side.
    write_reg(cfec_pkg::CFG_WIDTH, 14'($urandom_range(1, 8192)));
    write_reg(cfec_pkg::CFG_HEIGHT, 14'($urandom_range(1, 4096)));
    e = $urandom_range(1, 2048);
    write_reg(cfec_pkg::CFG_EDGE, 14'(e));
    random_pixels(450);
    idle_on = 1'b0;
    random_pixels(420);
    drain();

    $display("Covered %0d pixels on all face codes over five register settings,", pixels_sent);
    $display("from one-pixel faces to the largest images, with %0d results matched.",
             coord_sb.matched);
    if (coord_sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches in total", coord_sb.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", coord_sb.pending_coords.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- cubemap_face_to_equirect_coord_top.f -----
rtl/cfec_pkg.sv
rtl/cfec_cordic.sv
rtl/cubemap_face_to_equirect_coord_top.sv
bench/cubemap_face_to_equirect_coord_top_tb.sv
